>>> hdl/rcv_line_hex_payload_parser_top_defines.svh
// Assertion macros used by the checker file rcv_hex_chk.sv.
`ifndef RCV_LINE_HEX_PAYLOAD_PARSER_TOP_DEFINES_SVH
`define RCV_LINE_HEX_PAYLOAD_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define RCV_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rcv check failed");

// Next-cycle implication, sampled on aclk, off during reset.
`define RCV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rcv check failed");

`endif

>>> hdl/rcv_hex_pkg.sv
`timescale 1ns / 1ps

package rcv_hex_pkg;

    localparam int MAX_PAYLOAD      = 64;
    localparam int LINE_BUFFER_SIZE = 256;
    localparam int CNT_W            = 7;   // holds 0..MAX_PAYLOAD
    localparam int ADDR_W           = 6;   // indexes payload store
    localparam int FILL_W           = 8;   // holds 0..LINE_BUFFER_SIZE-1
    localparam int MARKER_LEN       = 5;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    localparam logic [FILL_W-1:0] FILL_LIMIT = FILL_W'(LINE_BUFFER_SIZE - 1);
    localparam logic [CNT_W-1:0]  CAP_MAX    = CNT_W'(MAX_PAYLOAD);

    // "+RCV=" one character at a time
    function automatic logic [7:0] marker_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h2B;
            3'd1:    ch = 8'h52;
            3'd2:    ch = 8'h43;
            3'd3:    ch = 8'h56;
            3'd4:    ch = 8'h3D;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Digit value in [3:0]; bit 4 set marks a non-hex character.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b0, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b0, 4'(c - 8'h37)};
        end else begin
            v = 5'h10;
        end
        return v;
    endfunction

endpackage

>>> hdl/rcv_hex_ram.sv
`timescale 1ns / 1ps

module rcv_hex_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/rcv_line_hex_payload_parser_top.sv
`timescale 1ns / 1ps
// Parsing: one received character per cycle, every cycle, while no payload is being read out.
// Closing comma of an error-free frame with decoded bytes: the store is read back through the
//   RAM output register and the output register onto m_*, one byte per cycle while m_tready allows;
//   input is held off until every read of the store is issued, which m_tready stalls can delay.
// The readout rate is set by the single read port of the payload store.
// Reset (aresetn low, synchronous): parse state, readout state and m_tvalid cleared, max_bytes set to 64.

module rcv_line_hex_payload_parser_top (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration: max_bytes
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,

    // received characters
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] rx_byte

    // decoded payload bytes
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // [7:0] payload_byte, [14:8] payload_length, [15] zero
    output logic        m_tlast      // last_byte
);

    typedef enum logic {
        ST_PARSE,
        ST_DRAIN
    } state_t;

    localparam int CW = rcv_hex_pkg::CNT_W;
    localparam int AW = rcv_hex_pkg::ADDR_W;
    localparam int FW = rcv_hex_pkg::FILL_W;

    state_t          state_reg, state_next;

    // line parser state
    logic [2:0]      mk_prog_reg, mk_prog_next;     // marker characters matched
    logic [1:0]      commas_reg, commas_next;       // commas after the marker
    logic [FW-1:0]   fill_reg, fill_next;           // characters in the line
    logic [3:0]      hi_nib_reg, hi_nib_next;       // first digit of the pair
    logic            pend_reg, pend_next;           // next char is second of pair
    logic            bad2_reg, bad2_next;           // pair not being decoded
    logic [CW-1:0]   cnt_reg, cnt_next;             // bytes decoded
    logic            ferr_reg, ferr_next;           // bad first digit seen
    logic [CW-1:0]   max_bytes_reg, max_bytes_next;

    // readout sequencer
    logic [AW-1:0]   rd_addr_reg, rd_addr_next;     // next entry to read
    logic [CW-1:0]   rd_left_reg, rd_left_next;     // reads still to issue
    logic [CW-1:0]   len_reg, len_next;             // length of frame being read
    logic            rd_vld_reg, rd_vld_next;       // RAM output holds a byte
    logic [AW-1:0]   rd_idx_reg, rd_idx_next;       // its index
    logic [CW-1:0]   rd_len_reg, rd_len_next;       // its frame length

    // output register
    logic            m_vld_reg, m_vld_next;
    logic [7:0]      m_byte_reg, m_byte_next;
    logic [CW-1:0]   m_len_reg, m_len_next;
    logic            m_last_reg, m_last_next;

    // payload store ports
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [7:0]      ram_wdata;
    logic            ram_re;
    logic [7:0]      ram_rdata;

    logic            in_xfer;
    logic            out_load;
    logic [CW-1:0]   cap;
    logic [4:0]      hv;
    logic            done;

    rcv_hex_ram #(
        .WIDTH (8),
        .DEPTH (rcv_hex_pkg::MAX_PAYLOAD)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == ST_PARSE);
    assign in_xfer  = s_tvalid && s_tready;

    // RAM output moves to the output register when that register is free or emptying
    assign out_load = rd_vld_reg && (!m_vld_reg || m_tready);
    // a new read may only replace the RAM output once it has been moved on
    assign ram_re   = (state_reg == ST_DRAIN) && (rd_left_reg != '0)
                      && (!rd_vld_reg || out_load);

    // effective cap: values above the store depth act as the depth
    assign cap = (max_bytes_reg > rcv_hex_pkg::CAP_MAX) ? rcv_hex_pkg::CAP_MAX : max_bytes_reg;
    assign hv  = rcv_hex_pkg::hex_value(s_tdata);

    always_comb begin
        state_next     = state_reg;
        mk_prog_next   = mk_prog_reg;
        commas_next    = commas_reg;
        fill_next      = fill_reg;
        hi_nib_next    = hi_nib_reg;
        pend_next      = pend_reg;
        bad2_next      = bad2_reg;
        cnt_next       = cnt_reg;
        ferr_next      = ferr_reg;
        max_bytes_next = cfg_we ? cfg_wdata : max_bytes_reg;
        rd_addr_next   = rd_addr_reg;
        rd_left_next   = rd_left_reg;
        len_next       = len_reg;
        rd_vld_next    = rd_vld_reg;
        rd_idx_next    = rd_idx_reg;
        rd_len_next    = rd_len_reg;
        m_vld_next     = m_vld_reg;
        m_byte_next    = m_byte_reg;
        m_len_next     = m_len_reg;
        m_last_next    = m_last_reg;
        ram_we         = 1'b0;
        ram_waddr      = cnt_reg[AW-1:0];
        ram_wdata      = {hi_nib_reg, hv[3:0]};
        done           = 1'b0;

        // output register: take the RAM output or drop a finished transfer
        if (out_load) begin
            m_vld_next  = 1'b1;
            m_byte_next = ram_rdata;
            m_len_next  = rd_len_reg;
            m_last_next = ({1'b0, rd_idx_reg} + CW'(1)) == rd_len_reg;
        end else if (m_tready) begin
            m_vld_next  = 1'b0;
        end

        // readout sequencer
        if (ram_re) begin
            rd_vld_next  = 1'b1;
            rd_idx_next  = rd_addr_reg;
            rd_len_next  = len_reg;
            rd_addr_next = rd_addr_reg + AW'(1);
            rd_left_next = rd_left_reg - CW'(1);
            if (rd_left_reg == CW'(1)) begin
                state_next = ST_PARSE;
            end
        end else if (out_load) begin
            rd_vld_next  = 1'b0;
        end

        // line parser, one character per transfer
        if (in_xfer) begin
            fill_next = fill_reg + FW'(1);
            if (mk_prog_reg < 3'(rcv_hex_pkg::MARKER_LEN)) begin
                if (s_tdata == rcv_hex_pkg::marker_char(mk_prog_reg)) begin
                    mk_prog_next = mk_prog_reg + 3'd1;
                end else begin
                    mk_prog_next = (s_tdata == rcv_hex_pkg::CH_PLUS) ? 3'd1 : 3'd0;
                end
            end else if (commas_reg < 2'd2) begin
                if (s_tdata == rcv_hex_pkg::CH_COMMA) begin
                    commas_next = commas_reg + 2'd1;
                end
            end else if (s_tdata == rcv_hex_pkg::CH_COMMA) begin
                done = 1'b1;
                if (!ferr_reg && cnt_reg != '0) begin
                    state_next   = ST_DRAIN;
                    rd_addr_next = '0;
                    rd_left_next = cnt_reg;
                    len_next     = cnt_reg;
                end
            end else if (!pend_reg) begin
                // first character of a pair: decode decision is made here
                if (!ferr_reg && cnt_reg < cap) begin
                    if (hv[4]) begin
                        ferr_next = 1'b1;
                        bad2_next = 1'b1;
                    end else begin
                        hi_nib_next = hv[3:0];
                        bad2_next   = 1'b0;
                    end
                end else begin
                    bad2_next = 1'b1;
                end
                pend_next = 1'b1;
            end else begin
                // second character: a non-hex one keeps the first digit alone
                if (!bad2_reg && !ferr_reg && cnt_reg < rcv_hex_pkg::CAP_MAX) begin
                    ram_we    = 1'b1;
                    ram_wdata = hv[4] ? {4'h0, hi_nib_reg} : {hi_nib_reg, hv[3:0]};
                    cnt_next  = cnt_reg + CW'(1);
                end
                pend_next = 1'b0;
            end

            // frame done or line buffer full: start a fresh line
            if (done || fill_next >= rcv_hex_pkg::FILL_LIMIT) begin
                mk_prog_next = '0;
                commas_next  = '0;
                fill_next    = '0;
                hi_nib_next  = '0;
                pend_next    = 1'b0;
                bad2_next    = 1'b0;
                cnt_next     = '0;
                ferr_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_PARSE;
            mk_prog_reg   <= '0;
            commas_reg    <= '0;
            fill_reg      <= '0;
            hi_nib_reg    <= '0;
            pend_reg      <= 1'b0;
            bad2_reg      <= 1'b0;
            cnt_reg       <= '0;
            ferr_reg      <= 1'b0;
            max_bytes_reg <= rcv_hex_pkg::CAP_MAX;
            rd_addr_reg   <= '0;
            rd_left_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            m_vld_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mk_prog_reg   <= mk_prog_next;
            commas_reg    <= commas_next;
            fill_reg      <= fill_next;
            hi_nib_reg    <= hi_nib_next;
            pend_reg      <= pend_next;
            bad2_reg      <= bad2_next;
            cnt_reg       <= cnt_next;
            ferr_reg      <= ferr_next;
            max_bytes_reg <= max_bytes_next;
            rd_addr_reg   <= rd_addr_next;
            rd_left_reg   <= rd_left_next;
            rd_vld_reg    <= rd_vld_next;
            m_vld_reg     <= m_vld_next;
        end
        // payload registers, no reset
        len_reg    <= len_next;
        rd_idx_reg <= rd_idx_next;
        rd_len_reg <= rd_len_next;
        m_byte_reg <= m_byte_next;
        m_len_reg  <= m_len_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {1'b0, m_len_reg, m_byte_reg};
    assign m_tlast  = m_last_reg;

endmodule

>>> hdl/rcv_hex_chk.sv
`timescale 1ns / 1ps
`include "rcv_line_hex_payload_parser_top_defines.svh"

module rcv_hex_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // stalled result holds
    `RCV_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    // length in 1..64
    `RCV_ASSERT_NOW(a_len_range, m_tvalid, m_tdata[14:8] != 7'd0 && m_tdata[14:8] <= 7'd64)
    // pad bit stays zero
    `RCV_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[15] == 1'b0)
    // a one-byte payload is its own last byte
    `RCV_ASSERT_NOW(a_single_last, m_tvalid && m_tdata[14:8] == 7'd1, m_tlast)

endmodule

bind rcv_line_hex_payload_parser_top rcv_hex_chk u_rcv_hex_chk (.*);

>>> bench/rcv_line_hex_payload_parser_top_tb.sv
`timescale 1ns / 1ps

module rcv_line_hex_payload_parser_top_tb;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 12;
    localparam int SETTLE_CYCLES   = 12;     // idle wait after the expected payload queue empties
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int CHARS_PER_PHASE = 100;
    localparam int MAX_REPORTS     = 10;
    localparam int WATCHDOG_NS     = 2_000_000;

    localparam logic [39:0] RCV_MARKER = "+RCV=";

    typedef struct packed {
        logic [7:0] data;
        logic [6:0] len;
        logic       last;
    } payload_beat_t;

    typedef struct {
        int         cfg;        // max_bytes written first, -1 keeps it
        string      head;
        int         pad;        // copies of pad_char sent after head
        logic [7:0] pad_char;
        string      tail;
        string      want;       // payload in hex, "" for none, "?" from predictor
    } dir_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [6:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    rcv_line_hex_payload_parser_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // parser shadow
    logic [6:0]  max_bytes_shadow = 7'd64;
    int          marker_pos   = 0;
    int          field_commas = 0;
    int          line_fill    = 0;
    int          byte_count   = 0;
    logic [3:0]  hi_digit     = '0;
    bit          second_half  = 1'b0;
    bit          skip_pair    = 1'b0;
    bit          frame_bad    = 1'b0;
    logic [7:0]  decoded_store [rcv_hex_pkg::MAX_PAYLOAD];

    payload_beat_t expected_payload [$];

    bit typed_row     = 1'b0;   // expectations of this row come from the table
    bit stall_req     = 1'b0;
    int tx_idle_pct   = 11;
    int rx_idle_pct   = 69;
    int fail_count    = 0;
    int counted_chars = 0;

    dir_row_t directed_rows [21] = '{
        '{-1, "+RCV=1,2,00FF,",        0, 8'h00, "",                  "00FF"},
        '{-1, "+RCV=7,3,aBcD,",        0, 8'h00, "",                  "ABCD"},
        '{-1, "+RCV=12,4,09afAF,",     0, 8'h00, "",                  "09AFAF"},
        '{-1, "xx+RC+RCV=1,1,12,",     0, 8'h00, "",                  "12"},
        '{-1, "++RCV=1,1,34,",         0, 8'h00, "",                  "34"},
        '{-1, "+RCV=1,1,G1,",          0, 8'h00, "",                  ""},
        '{-1, "+RCV=1,1,12G1,",        0, 8'h00, "",                  ""},
        '{-1, "+RCV=1,1,5Z,",          0, 8'h00, "",                  "05"},
        '{-1, "+RCV=1,1,abc,",         0, 8'h00, "",                  "AB"},
        '{-1, "+RCV=1,0,,",            0, 8'h00, "",                  ""},
        '{-1, "\377",                  2, 8'h00, "+RCV=1,1,7\377,",   "07"},
        '{ 1, "+RCV=1,3,1122zz,",      0, 8'h00, "",                  "11"},
        '{ 0, "+RCV=1,1,ZZAB,",        0, 8'h00, "",                  ""},
        '{64, "+RCV=1,64,",          128, "9",   ",",                 "?"},
        '{127, "+RCV=1,65,",         130, "F",   ",",                 "?"},
        // line fills up mid payload, next frame still decodes
        '{64, "+RCV=1,2,",           246, "0",   "+RCV=9,1,C3,",      "C3"},
        // closing comma lands one short of a full line
        '{-1, "+RCV=1,2,",           244, "1",   ",",                 "?"},
        // cap drops between the two digits of a pair
        '{ 2, "+RCV=1,2,AB1",          0, 8'h00, "",                  "?"},
        '{ 1, "2,",                    0, 8'h00, "",                  "?"},
        '{-1, "RCV=,,,+R+",            0, 8'h00, "",                  "?"},
        '{-1, "+RCV=12,4,DeadBEEF,",   0, 8'h00, "",                  "?"}
    };

    initial begin
        forever #HALF_PERIOD aclk = ~aclk;
    end

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return 16;
    endfunction

    function automatic logic [7:0] hex_char(input int v);
        if (v < 10) return 8'("0" + v);
        return 8'(($urandom_range(1) ? "a" : "A") + v - 10);
    endfunction

    task automatic parse_char(input logic [7:0] c);
        int cap;
        int v;
        bit closed;
        cap    = (max_bytes_shadow < rcv_hex_pkg::MAX_PAYLOAD) ?
                 int'(max_bytes_shadow) : rcv_hex_pkg::MAX_PAYLOAD;
        closed = 1'b0;
        line_fill++;
        if (marker_pos < rcv_hex_pkg::MARKER_LEN) begin
            if (c == RCV_MARKER[8*(rcv_hex_pkg::MARKER_LEN-1-marker_pos) +: 8]) begin
                marker_pos++;
            end else begin
                marker_pos = (c == rcv_hex_pkg::CH_PLUS) ? 1 : 0;
            end
        end else if (field_commas < 2) begin
            if (c == rcv_hex_pkg::CH_COMMA) field_commas++;
        end else if (c == rcv_hex_pkg::CH_COMMA) begin
            closed = 1'b1;
            if (!frame_bad && !typed_row) begin
                for (int k = 0; k < byte_count; k++) begin
                    expected_payload.push_back('{decoded_store[k], 7'(byte_count),
                                                 k == byte_count - 1});
                end
            end
        end else if (!second_half) begin
            // decode or skip is fixed at the first digit
            skip_pair = 1'b1;
            if (!frame_bad && byte_count < cap) begin
                v = nibble_of(c);
                if (v > 15) begin
                    frame_bad = 1'b1;
                end else begin
                    hi_digit  = 4'(v);
                    skip_pair = 1'b0;
                end
            end
            second_half = 1'b1;
        end else begin
            if (!skip_pair && !frame_bad && byte_count < rcv_hex_pkg::MAX_PAYLOAD) begin
                v = nibble_of(c);
                decoded_store[byte_count] = (v < 16) ? {hi_digit, 4'(v)} : {4'h0, hi_digit};
                byte_count++;
            end
            second_half = 1'b0;
        end
        if (closed || line_fill >= rcv_hex_pkg::LINE_BUFFER_SIZE - 1) begin
            marker_pos   = 0;
            field_commas = 0;
            line_fill    = 0;
            byte_count   = 0;
            hi_digit     = '0;
            second_half  = 1'b0;
            skip_pair    = 1'b0;
            frame_bad    = 1'b0;
        end
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("mismatch: %s", msg);
    endtask

    task automatic check_beat();
        payload_beat_t want;
        if (expected_payload.size() == 0) begin
            note_failure($sformatf("unexpected byte %02h len %0d last %0b",
                                   m_tdata[7:0], m_tdata[14:8], m_tlast));
            return;
        end
        want = expected_payload.pop_front();
        if (m_tdata[7:0] !== want.data || m_tdata[14:8] !== want.len ||
            m_tdata[15] !== 1'b0 || m_tlast !== want.last) begin
            note_failure($sformatf("got %04h last %0b, want byte %02h len %0d last %0b",
                                   m_tdata, m_tlast, want.data, want.len, want.last));
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) parse_char(s_tdata);
            if (m_tvalid && m_tready) check_beat();
        end
    end

    // sink side, with an optional long hold-off
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_req) begin
                stall_req = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        counted_chars++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (expected_payload.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_max_bytes(input logic [6:0] v);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        max_bytes_shadow = v;
    endtask

    task automatic run_row(input dir_row_t r);
        int nbytes;
        int v_hi;
        int v_lo;
        if (r.cfg >= 0) begin
            wait_drained();
            write_max_bytes(7'(r.cfg));
        end
        typed_row = (r.want != "?");
        if (typed_row) begin
            nbytes = r.want.len() / 2;
            for (int i = 0; i < nbytes; i++) begin
                v_hi = nibble_of(r.want[2*i]);
                v_lo = nibble_of(r.want[2*i+1]);
                expected_payload.push_back('{8'(v_hi * 16 + v_lo), 7'(nbytes),
                                             i == nbytes - 1});
            end
        end
        send_text(r.head);
        repeat (r.pad) send_char(r.pad_char);
        send_text(r.tail);
        typed_row = 1'b0;
    endtask

    // pay_len >= 0 gives a clean frame with that many payload characters
    task automatic send_random_line(input int pay_len);
        int n;
        bit clean;
        logic [7:0] c;
        clean = (pay_len >= 0);
        if (!clean && $urandom_range(99) < 10) begin
            // noise, not counted
            n = $urandom_range(1, 12);
            repeat (n) send_char(8'($urandom_range(255)));
            counted_chars -= n;
            return;
        end
        repeat ($urandom_range(0, 2)) send_char(8'($urandom_range(255)));
        for (int i = 0; i < rcv_hex_pkg::MARKER_LEN; i++) begin
            c = RCV_MARKER[8*(rcv_hex_pkg::MARKER_LEN-1-i) +: 8];
            if (!clean && $urandom_range(99) < 4) c = 8'($urandom_range(255));
            send_char(c);
        end
        repeat ($urandom_range(1, 3)) send_char(8'("0" + $urandom_range(9)));
        send_char(rcv_hex_pkg::CH_COMMA);
        repeat ($urandom_range(1, 2)) send_char(8'("0" + $urandom_range(9)));
        send_char(rcv_hex_pkg::CH_COMMA);
        if (clean) n = pay_len;
        else if ($urandom_range(19) == 0) n = $urandom_range(13, 140);
        else n = $urandom_range(0, 12);
        repeat (n) begin
            if (!clean && $urandom_range(99) < 3) c = 8'($urandom_range(255));
            else c = hex_char($urandom_range(15));
            send_char(c);
        end
        if (clean || $urandom_range(99) >= 5) send_char(rcv_hex_pkg::CH_COMMA);
    endtask

    task automatic random_phase();
        int phase_base;
        phase_base = counted_chars;
        while (counted_chars - phase_base < CHARS_PER_PHASE) send_random_line(-1);
    endtask

    initial begin : stimulus
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) run_row(directed_rows[i]);

        wait_drained();
        write_max_bytes(7'($urandom_range(1, 127)));
        random_phase();

        wait_drained();
        tx_idle_pct = 69;
        rx_idle_pct = 11;
        write_max_bytes(7'($urandom_range(0, 10)));
        random_phase();

        wait_drained();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_max_bytes(7'd127);
        // three commas close any line left open, so the next frame starts clean
        send_text(",,,");
        wait_drained();
        // sink stalls through a long readout while more lines are offered
        stall_req = 1'b1;
        send_random_line(80);
        random_phase();

        wait_drained();
        if (fail_count == 0 && expected_payload.size() == 0) begin
            $display("rcv_line_hex_payload_parser_top regression: pass");
        end else begin
            $display("rcv_line_hex_payload_parser_top regression: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #(WATCHDOG_NS);
        $display("rcv_line_hex_payload_parser_top regression: fail");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/rcv_hex_pkg.sv
hdl/rcv_hex_ram.sv
hdl/rcv_line_hex_payload_parser_top.sv
hdl/rcv_hex_chk.sv
bench/rcv_line_hex_payload_parser_top_tb.sv
